[sv/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[sv/itoa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and the digit character table for the converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_BITS = 64;
  localparam int NUM_CELLS  = VALUE_BITS;
  localparam int CNT_W      = $clog2(NUM_CELLS + 1);

  localparam logic [4:0] RADIX_MIN  = 5'd2;
  localparam logic [4:0] RADIX_MAX  = 5'd16;
  localparam logic [4:0] RADIX_TEN  = 5'd10;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  typedef logic [3:0] digit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic shift;
  } ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] ndig;
    digit_t           top;
  } cells_stat_t;

  function automatic logic [4:0] sat_radix(input logic [4:0] r);
    logic [4:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [7:0] digit_char(input digit_t d);
    logic [7:0] ch;
    case (d)
      4'h0:    ch = 8'h30;
      4'h1:    ch = 8'h31;
      4'h2:    ch = 8'h32;
      4'h3:    ch = 8'h33;
      4'h4:    ch = 8'h34;
      4'h5:    ch = 8'h35;
      4'h6:    ch = 8'h36;
      4'h7:    ch = 8'h37;
      4'h8:    ch = 8'h38;
      4'h9:    ch = 8'h39;
      4'ha:    ch = 8'h61;
      4'hb:    ch = 8'h62;
      4'hc:    ch = 8'h63;
      4'hd:    ch = 8'h64;
      4'he:    ch = 8'h65;
      default: ch = 8'h66;
    endcase
    return ch;
  endfunction

endpackage

[sv/itoa_mag.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_mag
// Takes the magnitude of the value and shifts it out one bit per cycle while step is set.
// ----------------------------------------------------------------------------
module itoa_mag (
  input  logic                clk,
  input  itoa_pkg::ctrl_t     ctl,
  input  logic [63:0]         value,
  input  logic [4:0]          radix,
  output logic                bit_out,
  output logic                sgn,
  output logic [4:0]          rad
);

  logic [itoa_pkg::VALUE_BITS-1:0] v;
  logic [itoa_pkg::VALUE_BITS-1:0] mag;
  logic [4:0]                      rad_sat;

  assign v       = value[itoa_pkg::VALUE_BITS-1:0];
  assign rad_sat = itoa_pkg::sat_radix(radix);
  assign bit_out = mag[itoa_pkg::VALUE_BITS-1];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      // most negative value negates to itself, read as unsigned magnitude
      mag <= v[itoa_pkg::VALUE_BITS-1] ? (~v + itoa_pkg::VALUE_BITS'(1)) : v;
      rad <= rad_sat;
      sgn <= v[itoa_pkg::VALUE_BITS-1] && (rad_sat == itoa_pkg::RADIX_TEN);
    end else if (ctl.step) begin
      mag <= {mag[itoa_pkg::VALUE_BITS-2:0], 1'b0};
    end
  end

endmodule

[sv/itoa_cells.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_cells
// Row of radix-r digit cells: each step doubles the held number and adds the
// incoming bit; afterwards the row shifts digits out from the top.
// ----------------------------------------------------------------------------
module itoa_cells (
  input  logic                  clk,
  input  itoa_pkg::ctrl_t       ctl,
  input  logic                  bit_in,
  input  logic [4:0]            rad,
  output itoa_pkg::cells_stat_t stat
);

  localparam int N = itoa_pkg::NUM_CELLS;

  itoa_pkg::digit_t [N-1:0]     dig;
  itoa_pkg::digit_t [N-1:0]     dig_next;
  logic [itoa_pkg::CNT_W-1:0]   len;
  logic [4:0]                   dbl [N];
  logic [4:0]                   tmp [N];
  logic [N-1:0]                 gen;
  logic [N-1:0]                 prop;
  logic [N:0]                   sum;
  logic [N:0]                   carry;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      dbl[i]  = {dig[i], 1'b0};
      gen[i]  = (dbl[i] >= rad);
      prop[i] = (dbl[i] == (rad - 5'd1));
    end
  end

  // carry lookahead across the cells done as one add
  assign sum   = {1'b0, gen | prop} + {1'b0, gen} + {{N{1'b0}}, bit_in};
  assign carry = sum ^ {1'b0, prop};

  always_comb begin
    for (int i = 0; i < N; i++) begin
      tmp[i]      = dbl[i] + {4'b0, carry[i]} - (carry[i+1] ? rad : 5'd0);
      dig_next[i] = tmp[i][3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dig <= '0;
      len <= '0;
    end else if (ctl.step) begin
      dig <= dig_next;
      // the first zero cell takes the carry, so length grows by it
      len <= len + itoa_pkg::CNT_W'(carry[len]);
    end else if (ctl.shift) begin
      dig <= {dig[N-2:0], 4'h0};
    end
  end

  assign stat = '{ndig: ((len == '0) ? itoa_pkg::CNT_W'(1) : len), top: dig[N-1]};

endmodule

[sv/itoa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: load, convert one bit per cycle, skip leading zero cells, emit any minus sign, emit.
// ----------------------------------------------------------------------------
module itoa_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       out_ready,
  input  logic                       sgn,
  input  logic [itoa_pkg::CNT_W-1:0] ndig,
  output itoa_pkg::ctrl_t            ctl,
  output logic                       in_ready,
  output logic                       out_valid,
  output logic                       out_last,
  output logic                       minus_sel
);

  itoa_pkg::state_t           state;
  itoa_pkg::state_t           state_next;
  logic [itoa_pkg::CNT_W-1:0] cnt;
  logic [itoa_pkg::CNT_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itoa_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      itoa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = itoa_pkg::ST_CONV;
          cnt_next   = itoa_pkg::CNT_W'(itoa_pkg::VALUE_BITS);
        end
      end
      itoa_pkg::ST_CONV: begin
        cnt_next = cnt - itoa_pkg::CNT_W'(1);
        if (cnt == itoa_pkg::CNT_W'(1)) begin
          state_next = itoa_pkg::ST_SKIP;
          cnt_next   = itoa_pkg::CNT_W'(itoa_pkg::NUM_CELLS);
        end
      end
      itoa_pkg::ST_SKIP: begin
        if (cnt == ndig) begin
          state_next = sgn ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
        end else begin
          cnt_next = cnt - itoa_pkg::CNT_W'(1);
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (out_ready) state_next = itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_EMIT: begin
        if (out_ready) begin
          cnt_next = cnt - itoa_pkg::CNT_W'(1);
          if (cnt == itoa_pkg::CNT_W'(1)) state_next = itoa_pkg::ST_IDLE;
        end
      end
      default: state_next = itoa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    minus_sel = 1'b0;
    case (state)
      itoa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      itoa_pkg::ST_CONV: ctl.step = 1'b1;
      itoa_pkg::ST_SKIP: ctl.shift = (cnt != ndig);
      itoa_pkg::ST_SIGN: begin
        out_valid = 1'b1;
        minus_sel = 1'b1;
      end
      itoa_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        out_last  = (cnt == itoa_pkg::CNT_W'(1));
        ctl.shift = out_ready;
      end
      default: ctl = '0;
    endcase
  end

endmodule

[sv/integer_to_ascii_radix.sv]
`timescale 1ns / 1ps
// after the input transaction the value is shifted into the digit cells and leading zero cells are skipped
// before the first character; a new item is taken only once the last character of the previous one has left
// the shift into the digit cells takes one bit per cycle, then the digits shift out from the top
// characters leave one per cycle while the output side is ready
// reset is synchronous, active high, and returns the sequencer to idle
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts a signed integer to ASCII text in radix 2 to 16, top digit first.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] value,
  input  logic [4:0]  radix,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  character,
  output logic        last
);

  itoa_pkg::ctrl_t       ctl;
  itoa_pkg::cells_stat_t stat;
  logic                  bit_s;
  logic                  sgn;
  logic [4:0]            rad;
  logic                  minus_sel;

  itoa_mag u_mag (
    .clk     (clk),
    .ctl     (ctl),
    .value   (value),
    .radix   (radix),
    .bit_out (bit_s),
    .sgn     (sgn),
    .rad     (rad)
  );

  itoa_cells u_cells (
    .clk    (clk),
    .ctl    (ctl),
    .bit_in (bit_s),
    .rad    (rad),
    .stat   (stat)
  );

  itoa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .sgn       (sgn),
    .ndig      (stat.ndig),
    .ctl       (ctl),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_last  (last),
    .minus_sel (minus_sel)
  );

  assign character = minus_sel ? itoa_pkg::CHAR_MINUS : itoa_pkg::digit_char(stat.top);

endmodule

[sv/itoa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itoa_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] character,
  input logic       last
);

  logic [8:0] out_word;

  assign out_word = {character, last};

  // a stalled output transaction holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))

  // one item at a time: never taking input while text is pending
  `ASSERT_SAME(a_no_overlap, clk, rst, in_ready, !out_valid)

  // an accepted input transaction starts a conversion
  `ASSERT_NEXT(a_busy_after_in, clk, rst, in_valid && in_ready, !in_ready)

  // the final character ends the item
  `ASSERT_NEXT(a_idle_after_last, clk, rst, out_valid && out_ready && last, in_ready)

  // the minus sign never closes the text
  `ASSERT_SAME(a_last_is_digit, clk, rst, out_valid && last, character != itoa_pkg::CHAR_MINUS)

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .character (character),
  .last      (last)
);

[verif/integer_to_ascii_radix_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_tb
// Self-checking bench for the integer to ASCII converter: directed corner
// values and random values in random radices are converted, each character is
// predicted from the value and radix and checked against the output stream
// while both sides of the handshake idle and stall at random.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 2 * itoa_pkg::VALUE_BITS + 8;
  localparam int RANDOM_ITEMS = 94;
  localparam string GLYPHS    = "0123456789abcdef";

  typedef struct {
    logic [7:0] code;
    logic       is_last;
  } text_char_t;

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_SPARSE
  } ready_mode_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [63:0] value     = '0;
  logic [4:0]  radix     = itoa_pkg::RADIX_TEN;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  character;
  logic        last;

  text_char_t  pending_text[$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          burst_left     = 4;
  ready_mode_t ready_mode     = READY_ALWAYS;
  int          mode_left      = 40;

  integer_to_ascii_radix i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .radix     (radix),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

  always #6 clk = ~clk;

  // expected text of one value, top digit first
  function automatic void predict_text(input logic [63:0] val, input logic [4:0] rad);
    logic [63:0] mag;
    logic [63:0] base;
    logic [3:0]  digit_stack[$];
    text_char_t  ch;
    int          i;
    base = 64'(rad);
    if (rad < itoa_pkg::RADIX_MIN) base = 64'(itoa_pkg::RADIX_MIN);
    if (rad > itoa_pkg::RADIX_MAX) base = 64'(itoa_pkg::RADIX_MAX);
    // magnitude of the most negative value still fits unsigned
    mag = val[63] ? (~val + 64'd1) : val;
    if (val[63] && base == 64'(itoa_pkg::RADIX_TEN)) begin
      ch.code    = itoa_pkg::CHAR_MINUS;
      ch.is_last = 1'b0;
      pending_text.push_back(ch);
    end
    do begin
      digit_stack.push_back(4'(mag % base));
      mag = mag / base;
    end while (mag != 64'd0);
    for (i = digit_stack.size() - 1; i >= 0; i--) begin
      ch.code    = GLYPHS[digit_stack[i]];
      ch.is_last = (i == 0);
      pending_text.push_back(ch);
    end
  endfunction

  // one transaction on the input side, then maybe a gap
  task automatic send_number(input logic [63:0] val, input logic [4:0] rad);
    int gap;
    in_valid <= 1'b1;
    value    <= val;
    radix    <= rad;
    do @(posedge clk); while (!in_ready);
    predict_text(val, rad);
    burst_left--;
    if (burst_left <= 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          nbits;
    v     = {$urandom, $urandom};
    nbits = $urandom_range(0, 64);
    if (nbits < 64) v = v & ((64'd1 << nbits) - 64'd1);
    if ($urandom_range(0, 3) == 0) v = -v;
    return v;
  endfunction

  function automatic logic [4:0] random_radix();
    if ($urandom_range(0, 7) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(itoa_pkg::RADIX_MIN, itoa_pkg::RADIX_MAX));
  endfunction

  task automatic test_zero();
    send_number(64'd0, itoa_pkg::RADIX_TEN);
    send_number(64'd0, itoa_pkg::RADIX_MIN);
    send_number(64'd0, itoa_pkg::RADIX_MAX);
  endtask

  task automatic test_extremes();
    send_number(64'h7fff_ffff_ffff_ffff, itoa_pkg::RADIX_MIN);
    send_number(64'h7fff_ffff_ffff_ffff, itoa_pkg::RADIX_TEN);
    send_number(64'h7fff_ffff_ffff_ffff, itoa_pkg::RADIX_MAX);
    send_number(64'h8000_0000_0000_0000, itoa_pkg::RADIX_TEN);
    send_number(64'h8000_0000_0000_0000, itoa_pkg::RADIX_MIN);
    send_number(64'h8000_0000_0000_0000, itoa_pkg::RADIX_MAX);
    send_number(64'hffff_ffff_ffff_ffff, itoa_pkg::RADIX_TEN);
    send_number(64'hffff_ffff_ffff_ffff, 5'd3);
  endtask

  // minus sign only in base ten, magnitude digits elsewhere
  task automatic test_sign_and_digits();
    send_number(64'h0123_4567_89ab_cdef, itoa_pkg::RADIX_MAX);
    send_number(-64'h0123_4567_89ab_cdef, itoa_pkg::RADIX_MAX);
    send_number(-64'd1234567890, itoa_pkg::RADIX_TEN);
    send_number(-64'd1234567890, 5'd7);
  endtask

  task automatic test_radix_saturation();
    send_number(64'd1000, 5'd0);
    send_number(-64'd77, 5'd1);
    send_number(64'hdead_beef, 5'd17);
    send_number(-64'h1234_5678_9abc, 5'd31);
  endtask

  // receiver sees a fully idle block in the middle of traffic
  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 4; i++) send_number(random_value(), random_radix());
    wait_for_drain();
    for (i = 0; i < 3; i++) send_number(random_value(), random_radix());
  endtask

  task automatic test_random();
    int i;
    for (i = 0; i < RANDOM_ITEMS; i++) send_number(random_value(), random_radix());
  endtask

  // receiver stall pattern, switching mode now and then
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left <= 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 2));
        mode_left  <= $urandom_range(20, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_RANDOM: out_ready <= $urandom_range(0, 1);
        default:      out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_text
    text_char_t exp_char;
    if (!rst && out_valid && out_ready) begin
      if (pending_text.size() == 0) begin
        $display("%0t: unexpected character %h last %b", $time, character, last);
        mismatch_count++;
      end else begin
        exp_char = pending_text.pop_front();
        if (character !== exp_char.code) begin
          $display("%0t: character expected %h actual %h", $time, exp_char.code, character);
          mismatch_count++;
        end
        if (last !== exp_char.is_last) begin
          $display("%0t: last expected %b actual %b", $time, exp_char.is_last, last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero();
    test_extremes();
    test_sign_and_digits();
    test_radix_saturation();
    test_drain_pause();
    test_random();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_text.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
